/* rtl/csmv_pkg.sv */
package csmv_pkg;

   // fixed field widths
   localparam int IDX_W = 11;
   localparam int VAL_W = 32;
   localparam int Y_W = 64;
   localparam int CMD_W = 2;
   localparam int STATUS_W = 2;
   localparam int OP_W = 3;

   typedef logic [IDX_W-1:0] idx_type;

   // command codes on the request port
   localparam logic [CMD_W-1:0] CMD_LOAD_X = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_Y = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MATRIX = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ_Y = 2'd3;

   // classified operations handed to the back end
   localparam logic [OP_W-1:0] OP_RANGE = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD_X = 3'd1;
   localparam logic [OP_W-1:0] OP_LOAD_Y = 3'd2;
   localparam logic [OP_W-1:0] OP_READ_Y = 3'd3;
   localparam logic [OP_W-1:0] OP_MAC = 3'd4;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAT = 2'd2;

   // control register map
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_ADDR_W-1:0] REG_SYMMETRIC = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_INDEX_BASE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_VECTOR_LENGTH = 2'd2;
   localparam logic [IDX_W-1:0] VLEN_RESET = 11'd1024;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   // one classified item, indices already rebased and checked
   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic                    mirror;
      idx_type                 row;
      idx_type                 col;
      logic signed [VAL_W-1:0] entry_value;
      logic signed [Y_W-1:0]   y_init;
   } item_type;

endpackage

/* rtl/coo_sparse_matvec_accumulate.sv */
// channel   ports                                         handshake
// request   start, busy, req_cmd .. req_y_init            taken when start && !busy
// response  rsp_valid, rsp_y_value, rsp_status            one-cycle strobe, no stall
// control   csr_valid, csr_ready, csr_index, csr_data     written when valid && ready
//
// back end path: loads and range errors return straight to idle, a y read
// passes READ, a matrix entry MUL and ADD, a mirrored one MUL and ADD twice
// (one multiplier, one y write port); load and error responses return soonest
// reset is synchronous and clears control and state; x and y entries must be written
// before they are read, so there is no clearing pass
// busy rises when the two-entry queue between front and back is full
module coo_sparse_matvec_accumulate #(
   parameter int MAX_N = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [csmv_pkg::CMD_W-1:0]          req_cmd,
   input  logic [csmv_pkg::IDX_W-1:0]          req_row_index,
   input  logic [csmv_pkg::IDX_W-1:0]          req_col_index,
   input  logic signed [csmv_pkg::VAL_W-1:0]   req_entry_value,
   input  logic signed [csmv_pkg::Y_W-1:0]     req_y_init,
   output logic                                rsp_valid,
   output logic signed [csmv_pkg::Y_W-1:0]     rsp_y_value,
   output logic [csmv_pkg::STATUS_W-1:0]       rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [csmv_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [csmv_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic                q_full, q_push, q_empty, q_pop;
   csmv_pkg::item_type  q_item, q_head;

   // decode, rebase and check
   csmv_front #(
      .MAX_N(MAX_N)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_row_index(req_row_index),
      .req_col_index(req_col_index),
      .req_entry_value(req_entry_value),
      .req_y_init(req_y_init),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .q_full(q_full),
      .q_push(q_push),
      .q_item(q_item)
   );

   // decoupling queue
   csmv_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_item(q_item),
      .full(q_full),
      .pop(q_pop),
      .empty(q_empty),
      .head(q_head)
   );

   // memories and multiply-accumulate
   csmv_back #(
      .MAX_N(MAX_N)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_head(q_head),
      .q_pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_y_value(rsp_y_value),
      .rsp_status(rsp_status)
   );

endmodule

/* rtl/csmv_front.sv */
module csmv_front #(
   parameter int MAX_N = 1024
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [csmv_pkg::CMD_W-1:0]               req_cmd,
   input  logic [csmv_pkg::IDX_W-1:0]               req_row_index,
   input  logic [csmv_pkg::IDX_W-1:0]               req_col_index,
   input  logic signed [csmv_pkg::VAL_W-1:0]        req_entry_value,
   input  logic signed [csmv_pkg::Y_W-1:0]          req_y_init,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [csmv_pkg::CSR_ADDR_W-1:0]          csr_index,
   input  logic [csmv_pkg::CSR_DATA_W-1:0]          csr_data,
   input  logic                                     q_full,
   output logic                                     q_push,
   output csmv_pkg::item_type                       q_item
);

   localparam int IW = csmv_pkg::IDX_W;
   localparam int LIM = (MAX_N < (1 << IW)) ? MAX_N : (1 << IW);
   localparam logic [IW:0] LIMIT = (IW + 1)'(LIM);

   logic           sym_ff, sym_in;
   logic           base_ff, base_in;
   logic [IW-1:0]  vlen_ff, vlen_in;
   logic [IW-1:0]  row_adj, col_adj;
   logic           row_ok, col_ok;

   // control registers, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      sym_in = sym_ff;
      base_in = base_ff;
      vlen_in = vlen_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            csmv_pkg::REG_SYMMETRIC: sym_in = csr_data[0];
            csmv_pkg::REG_INDEX_BASE: base_in = csr_data[0];
            csmv_pkg::REG_VECTOR_LENGTH: vlen_in = csr_data[IW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= 1'b0;
         base_ff <= 1'b0;
         vlen_ff <= csmv_pkg::VLEN_RESET;
      end else begin
         sym_ff <= sym_in;
         base_ff <= base_in;
         vlen_ff <= vlen_in;
      end
   end

   // rebase and range check both indices
   assign row_adj = req_row_index - IW'(base_ff);
   assign col_adj = req_col_index - IW'(base_ff);
   assign row_ok = (req_row_index >= IW'(base_ff)) && (row_adj < vlen_ff)
                   && ({1'b0, row_adj} < LIMIT);
   assign col_ok = (req_col_index >= IW'(base_ff)) && (col_adj < vlen_ff)
                   && ({1'b0, col_adj} < LIMIT);

   // accept while the queue has room
   assign busy = q_full;
   assign q_push = start && !busy;

   // classify the beat
   always_comb begin
      q_item.op = csmv_pkg::OP_RANGE;
      q_item.mirror = 1'b0;
      q_item.row = row_adj;
      q_item.col = col_adj;
      q_item.entry_value = req_entry_value;
      q_item.y_init = req_y_init;
      if (row_ok) begin
         unique case (req_cmd)
            csmv_pkg::CMD_LOAD_X: q_item.op = csmv_pkg::OP_LOAD_X;
            csmv_pkg::CMD_LOAD_Y: q_item.op = csmv_pkg::OP_LOAD_Y;
            csmv_pkg::CMD_READ_Y: q_item.op = csmv_pkg::OP_READ_Y;
            csmv_pkg::CMD_MATRIX: begin
               if (col_ok) begin
                  q_item.op = csmv_pkg::OP_MAC;
                  q_item.mirror = sym_ff && (row_adj != col_adj);
               end
            end
            default: q_item.op = csmv_pkg::OP_RANGE;
         endcase
      end
   end

endmodule

/* rtl/csmv_queue.sv */
module csmv_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  csmv_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output csmv_pkg::item_type head
);

   csmv_pkg::item_type                 slot_ff [csmv_pkg::QUEUE_DEPTH];
   logic [csmv_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [csmv_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [csmv_pkg::QCNT_W-1:0]        count_ff, count_in;

   assign full = (count_ff == csmv_pkg::QCNT_W'(csmv_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/csmv_back.sv */
module csmv_back #(
   parameter int MAX_N = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  csmv_pkg::item_type                  q_head,
   output logic                                q_pop,
   output logic                                rsp_valid,
   output logic signed [csmv_pkg::Y_W-1:0]     rsp_y_value,
   output logic [csmv_pkg::STATUS_W-1:0]       rsp_status
);

   localparam int AW = (MAX_N > 2) ? $clog2(MAX_N) : 1;
   localparam int IW = csmv_pkg::IDX_W;
   localparam int WW = (AW > IW) ? AW : IW;
   localparam int YW = csmv_pkg::Y_W;
   localparam int VW = csmv_pkg::VAL_W;
   localparam logic signed [YW-1:0] Y_MAX = {1'b0, {(YW-1){1'b1}}};
   localparam logic signed [YW-1:0] Y_MIN = {1'b1, {(YW-1){1'b0}}};

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_MUL = 2'd2;
   localparam logic [1:0] S_ADD = 2'd3;

   function automatic logic [AW-1:0] to_addr(input csmv_pkg::idx_type idx);
      logic [WW-1:0] wide;
      wide = WW'(idx);
      return wide[AW-1:0];
   endfunction

   logic [VW-1:0]          x_mem [MAX_N];
   logic [YW-1:0]          y_mem [MAX_N];

   logic [1:0]             state_ff, state_in;
   csmv_pkg::item_type     item_ff, item_in;
   logic                   phase_ff, phase_in;
   logic                   sat_ff, sat_in;
   logic signed [YW-1:0]   prod_ff, prod_in;
   logic signed [VW-1:0]   x_rd_ff;
   logic signed [YW-1:0]   y_rd_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [YW-1:0]   rsp_y_ff, rsp_y_in;
   logic [csmv_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                   x_we, x_re, y_we, y_re;
   logic [AW-1:0]          x_waddr, x_raddr, y_waddr, y_raddr;
   logic [YW-1:0]          y_wdata;
   logic                   second_issue;
   logic signed [YW:0]     sum;
   logic                   sat_now, sat_any;
   logic signed [YW-1:0]   sum_sat;

   assign q_pop = (state_ff == S_IDLE) && !q_empty;
   assign second_issue = (state_ff == S_ADD) && !phase_ff && item_ff.mirror;

   // saturating accumulate of the registered product
   assign sum = {y_rd_ff[YW-1], y_rd_ff} + {prod_ff[YW-1], prod_ff};
   assign sat_now = (sum[YW] != sum[YW-1]);
   assign sum_sat = sat_now ? (sum[YW] ? Y_MIN : Y_MAX) : sum[YW-1:0];
   assign sat_any = sat_ff || sat_now;

   // memory port steering
   assign x_we = q_pop && (q_head.op == csmv_pkg::OP_LOAD_X);
   assign x_waddr = to_addr(q_head.row);
   assign x_re = (q_pop && (q_head.op == csmv_pkg::OP_MAC)) || second_issue;
   assign x_raddr = (state_ff == S_IDLE) ? to_addr(q_head.col) : to_addr(item_ff.row);

   assign y_re = (q_pop && ((q_head.op == csmv_pkg::OP_MAC)
                            || (q_head.op == csmv_pkg::OP_READ_Y))) || second_issue;
   assign y_raddr = (state_ff == S_IDLE) ? to_addr(q_head.row) : to_addr(item_ff.col);
   assign y_we = (q_pop && (q_head.op == csmv_pkg::OP_LOAD_Y)) || (state_ff == S_ADD);
   assign y_waddr = (state_ff == S_IDLE) ? to_addr(q_head.row)
                  : (phase_ff ? to_addr(item_ff.col) : to_addr(item_ff.row));
   assign y_wdata = (state_ff == S_IDLE) ? q_head.y_init : sum_sat;

   always_ff @(posedge clock) begin
      if (x_we) begin
         x_mem[x_waddr] <= q_head.entry_value;
      end
      if (x_re) begin
         x_rd_ff <= x_mem[x_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (y_we) begin
         y_mem[y_waddr] <= y_wdata;
      end
      if (y_re) begin
         y_rd_ff <= y_mem[y_raddr];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      phase_in = phase_ff;
      sat_in = sat_ff;
      prod_in = prod_ff;
      rsp_valid_in = 1'b0;
      rsp_y_in = '0;
      rsp_status_in = csmv_pkg::ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               item_in = q_head;
               phase_in = 1'b0;
               sat_in = 1'b0;
               case (q_head.op)
                  csmv_pkg::OP_MAC: state_in = S_MUL;
                  csmv_pkg::OP_READ_Y: state_in = S_READ;
                  csmv_pkg::OP_RANGE: begin
                     rsp_valid_in = 1'b1;
                     rsp_status_in = csmv_pkg::ST_RANGE;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_y_in = y_rd_ff;
            state_in = S_IDLE;
         end
         S_MUL: begin
            prod_in = $signed(item_ff.entry_value) * $signed(x_rd_ff);
            state_in = S_ADD;
         end
         S_ADD: begin
            if (second_issue) begin
               phase_in = 1'b1;
               sat_in = sat_any;
               state_in = S_MUL;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_status_in = sat_any ? csmv_pkg::ST_SAT : csmv_pkg::ST_OK;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      phase_ff <= phase_in;
      sat_ff <= sat_in;
      prod_ff <= prod_in;
      rsp_y_ff <= rsp_y_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_y_value = rsp_y_ff;
   assign rsp_status = rsp_status_ff;

endmodule
